@@ rtl/ampe_pkg.sv @@
// Shared types, widths and codes for the attention mask pair evaluator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ampe_pkg;

  // Field widths
  localparam int unsigned POS_W     = 12;
  localparam int unsigned GROUP_W   = 16;
  localparam int unsigned ENTRY_W   = 13;
  localparam int unsigned WIN_W     = 13;
  localparam int unsigned DOCS      = 16;
  localparam int unsigned DOC_IDX_W = 4;
  localparam int unsigned DOC_CNT_W = 5;
  localparam int unsigned MASK_W    = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_CAUSAL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOC_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_BIDIR  = 3'd4;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 40;

  // Item kinds carried on the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // FP32 mask words
  localparam logic [MASK_W-1:0] MASK_ALLOWED = 32'h0000_0000;
  localparam logic [MASK_W-1:0] MASK_BLOCKED = 32'hFF80_0000;

  // Saturated document count: the table holds DOCS entries
  localparam logic [DOC_CNT_W-1:0] DOCS_SAT = DOC_CNT_W'(DOCS);

  typedef logic [DOCS-1:0][ENTRY_W-1:0] bound_tbl_t;

  typedef struct packed {
    logic                 causal;
    logic [WIN_W-1:0]     window;
    logic [DOC_CNT_W-1:0] doc_count;
    logic                 group_en;
    logic                 group_bidir;
  } cfg_t;

  // Bits 1..n set: the boundaries that must all be passed for document n
  function automatic logic [DOCS-1:0] run_mask(input int unsigned n);
    logic [DOCS-1:0] m;
    m = '0;
    for (int unsigned b = 1; b < DOCS; b++) begin
      if (b <= n) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ampe_doc_lookup.sv @@
// Document lookup for one position: thermometer code of passed boundaries.
// Depends on ampe_pkg for widths and the boundary table type.
`default_nettype none

module ampe_doc_lookup (
  input  wire logic [ampe_pkg::POS_W-1:0]     pos_i,
  input  wire logic [ampe_pkg::DOC_CNT_W-1:0] docs_i,
  input  wire ampe_pkg::bound_tbl_t           tbl_i,
  output logic      [ampe_pkg::DOCS-1:0]      run_o
);

  logic [ampe_pkg::DOCS-1:0] hit;

  // Compare the position against every active boundary
  always_comb begin
    hit = '0;
    for (int unsigned n = 1; n < ampe_pkg::DOCS; n++) begin
      hit[n] = (ampe_pkg::DOC_CNT_W'(n) < docs_i) &&
               ({1'b0, pos_i} >= tbl_i[n]);
    end
  end

  // Keep only the leading run of passed boundaries; its length is the document number
  assign run_o[0] = 1'b0;
  for (genvar g = 1; g < ampe_pkg::DOCS; g++) begin : g_run
    localparam logic [ampe_pkg::DOCS-1:0] RunM = ampe_pkg::run_mask(g);
    assign run_o[g] = ((hit & RunM) == RunM);
  end

endmodule

`default_nettype wire

@@ rtl/ampe_pair_judge.sv @@
// Rule evaluation for one query/key pair: causal, window, document, group.
// Depends on ampe_pkg and ampe_doc_lookup.
`default_nettype none

module ampe_pair_judge (
  input  wire ampe_pkg::cfg_t                   cfg_i,
  input  wire ampe_pkg::bound_tbl_t             tbl_i,
  input  wire logic [ampe_pkg::POS_W-1:0]       query_pos_i,
  input  wire logic [ampe_pkg::POS_W-1:0]       key_pos_i,
  input  wire logic [ampe_pkg::GROUP_W-1:0]     query_group_i,
  input  wire logic [ampe_pkg::GROUP_W-1:0]     key_group_i,
  output logic                                  allowed_o
);

  logic                           key_after;
  logic [ampe_pkg::POS_W-1:0]     pos_gap;
  logic                           causal_hit;
  logic                           window_hit;
  logic                           doc_hit;
  logic                           group_hit;
  logic [ampe_pkg::DOC_CNT_W-1:0] docs_sat;
  logic [ampe_pkg::DOCS-1:0]      q_run;
  logic [ampe_pkg::DOCS-1:0]      k_run;

  assign key_after = key_pos_i > query_pos_i;
  assign pos_gap   = key_after ? (key_pos_i - query_pos_i) : (query_pos_i - key_pos_i);

  // Clamp the document count to the table depth
  assign docs_sat = (cfg_i.doc_count > ampe_pkg::DOCS_SAT) ? ampe_pkg::DOCS_SAT
                                                           : cfg_i.doc_count;

  ampe_doc_lookup u_doc_q (
    .pos_i  (query_pos_i),
    .docs_i (docs_sat),
    .tbl_i  (tbl_i),
    .run_o  (q_run)
  );

  ampe_doc_lookup u_doc_k (
    .pos_i  (key_pos_i),
    .docs_i (docs_sat),
    .tbl_i  (tbl_i),
    .run_o  (k_run)
  );

  // Any enabled rule that fires masks the pair
  assign causal_hit = cfg_i.causal && key_after;
  assign window_hit = (cfg_i.window != '0) && ({1'b0, pos_gap} >= cfg_i.window);
  assign doc_hit    = (cfg_i.doc_count != '0) && (q_run != k_run);
  assign group_hit  = cfg_i.group_en &&
                      ((query_group_i != key_group_i) || (!cfg_i.group_bidir && key_after));

  assign allowed_o = !(causal_hit || window_hit || doc_hit || group_hit);

endmodule

`default_nettype wire

@@ rtl/attention_mask_pair_eval_top.sv @@
// Top level of the attention mask pair evaluator: stream ports, item register,
// boundary table, row flag and result register. Depends on ampe_pkg, ampe_pair_judge.
//
// Usage:
//  - Input stream (s_axis_*): one item per handshake. tuser selects the kind:
//    load writes one boundary table entry and gives no result; evaluate judges
//    one query/key pair. tlast marks the last key of a query row.
//  - Output stream (m_axis_*): one result per evaluate item, in order.
//    tdata carries the allowed bit and the FP32 mask word; tuser carries the
//    row error flag, raised on a row's last key when no key of the row passed.
//  - Configuration channel (cfg_*): always ready; write only while idle.
//  - Path: an accepted item waits in the item register, then its result moves
//    to the result register, where it stays valid until taken.
//    Throughput: one item per cycle while the output is not stalled, set by
//    the single register-to-register evaluation path.
//  - A stalled receiver holds the result register; the item register still
//    drains loads and refills while the result waits, so input stalls only
//    when both registers hold evaluate work.
//  - Reset clears all configuration, the row flag and both valid flags. The
//    boundary table is not cleared; entries must be loaded before use.
`default_nettype none

module attention_mask_pair_eval_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ampe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ampe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [11:0] query_pos, [23:12] key_pos, [39:24] query_group, [55:40] key_group,
  // [59:56] entry_index, [72:60] entry_value, [79:73] zero
  input  wire logic [ampe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tlast,  // row_last
  input  wire logic                               s_axis_tuser,  // [0] operation
  // Output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] allowed, [32:1] mask_bits, [39:33] zero
  output logic      [ampe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                                    m_axis_tuser   // [0] row_error
);

  // Configuration registers
  ampe_pkg::cfg_t cfg_q;

  // Item register
  logic                               in_valid_q;
  logic                               in_op_q;
  logic [ampe_pkg::POS_W-1:0]         in_qpos_q;
  logic [ampe_pkg::POS_W-1:0]         in_kpos_q;
  logic [ampe_pkg::GROUP_W-1:0]       in_qgrp_q;
  logic [ampe_pkg::GROUP_W-1:0]       in_kgrp_q;
  logic                               in_last_q;
  logic [ampe_pkg::DOC_IDX_W-1:0]     in_eidx_q;
  logic [ampe_pkg::ENTRY_W-1:0]       in_eval_q;

  // Boundary table, row flag, result register
  ampe_pkg::bound_tbl_t tbl_q;
  logic                 row_any_q, row_any_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_allowed_q;
  logic                 out_err_q;

  logic in_accept;
  logic in_adv;
  logic eval_adv;
  logic load_adv;
  logic allowed;
  logic any_now;

  // Configuration writes are taken at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ampe_pkg::REG_CAUSAL:       cfg_q.causal      <= cfg_data_i[0];
        ampe_pkg::REG_WINDOW:       cfg_q.window      <= cfg_data_i;
        ampe_pkg::REG_DOC_COUNT:    cfg_q.doc_count   <= cfg_data_i[ampe_pkg::DOC_CNT_W-1:0];
        ampe_pkg::REG_GROUP_ENABLE: cfg_q.group_en    <= cfg_data_i[0];
        ampe_pkg::REG_GROUP_BIDIR:  cfg_q.group_bidir <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the item register: loads always drain, evaluates need a free result slot
  assign in_adv   = in_valid_q &&
                    ((in_op_q == ampe_pkg::OP_LOAD) || !out_valid_q || m_axis_tready);
  assign eval_adv = in_adv && (in_op_q == ampe_pkg::OP_EVAL);
  assign load_adv = in_adv && (in_op_q == ampe_pkg::OP_LOAD);

  assign s_axis_tready = !in_valid_q || in_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= s_axis_tuser;
      in_qpos_q <= s_axis_tdata[11:0];
      in_kpos_q <= s_axis_tdata[23:12];
      in_qgrp_q <= s_axis_tdata[39:24];
      in_kgrp_q <= s_axis_tdata[55:40];
      in_eidx_q <= s_axis_tdata[59:56];
      in_eval_q <= s_axis_tdata[72:60];
      in_last_q <= s_axis_tlast;
    end
  end

  // Write a boundary entry as its load leaves the item register
  always_ff @(posedge clk_i) begin
    if (load_adv) begin
      tbl_q[in_eidx_q] <= in_eval_q;
    end
  end

  ampe_pair_judge u_judge (
    .cfg_i         (cfg_q),
    .tbl_i         (tbl_q),
    .query_pos_i   (in_qpos_q),
    .key_pos_i     (in_kpos_q),
    .query_group_i (in_qgrp_q),
    .key_group_i   (in_kgrp_q),
    .allowed_o     (allowed)
  );

  // Track whether any key of the current row passed; clear at row end
  assign any_now   = row_any_q || allowed;
  assign row_any_d = eval_adv ? (any_now && !in_last_q) : row_any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_any_q <= 1'b0;
    end else begin
      row_any_q <= row_any_d;
    end
  end

  // Result register: fill on an evaluate, drop when taken
  assign out_valid_d = eval_adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_adv) begin
      out_allowed_q <= allowed;
      out_err_q     <= in_last_q && !any_now;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0,
                          (out_allowed_q ? ampe_pkg::MASK_ALLOWED : ampe_pkg::MASK_BLOCKED),
                          out_allowed_q};
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

@@ rtl/ampe_checker.sv @@
// Port-level checks for the attention mask pair evaluator, bound to the top level.
// Depends on ampe_pkg for widths and mask words.
`default_nettype none

module ampe_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tready,
  input  wire logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic [ampe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  wire logic                               m_axis_tuser
);

  // Mask word follows the allowed bit
  a_mask_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[0] && m_axis_tdata[32:1] == ampe_pkg::MASK_ALLOWED) ||
       (!m_axis_tdata[0] && m_axis_tdata[32:1] == ampe_pkg::MASK_BLOCKED)))
    else $error("mask word does not match allowed bit");

  // A row error can only come with a masked pair
  a_err_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[0])
    else $error("row error raised on an allowed pair");

  // A receiver that takes results never backs up the input
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is drained");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid just after reset");

endmodule

bind attention_mask_pair_eval_top ampe_checker u_ampe_checker (.*);

`default_nettype wire
